### design/tcphp_pkg.sv
// ----------------------------------------------------------------------------
// TCP header parser package
// Word types, record codes and header constants shared by the parser files.
// ----------------------------------------------------------------------------
package tcphp_pkg;

    // Header layout.
    localparam int FIXED_LEN   = 20;
    localparam int MIN_OFFSET  = 5;
    localparam int IDX_MAX     = 63;
    localparam logic [3:0] NIBBLE_MASK = 4'hf;

    // Record codes carried in record_type.
    localparam logic [2:0] RT_FIXED = 3'd0;
    localparam logic [2:0] RT_KIND  = 3'd1;
    localparam logic [2:0] RT_LEN   = 3'd2;
    localparam logic [2:0] RT_DATA  = 3'd3;
    localparam logic [2:0] RT_END   = 3'd4;
    localparam logic [2:0] RT_SHORT = 3'd5;
    localparam logic [2:0] RT_BAD   = 3'd6;

    // Option kinds with special meaning.
    localparam logic [7:0] KIND_EOL = 8'd0;
    localparam logic [7:0] KIND_NOP = 8'd1;

    typedef struct packed {
        logic [7:0] header_byte;
        logic       last_byte;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  record_type;
        logic        header_end;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] seq_num;
        logic [31:0] ack_number;
        logic [3:0]  offset_words;
        logic [7:0]  flag_bits;
        logic [15:0] win_size;
        logic [15:0] header_checksum;
        logic [15:0] urg_ptr;
        logic [7:0]  option_value;
    } out_word_t;

endpackage

### design/tcphp_parse.sv
// ----------------------------------------------------------------------------
// TCP header parser byte stage
// Input register, parse state and the per-byte decode of one header byte.
// ----------------------------------------------------------------------------
module tcphp_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  tcphp_pkg::in_word_t  byte_word,
    input  logic                 rec_ready,
    output logic                 rec_load,
    output tcphp_pkg::out_word_t rec_word
);

    typedef enum logic [2:0] {
        PH_FIXED,
        PH_KIND,
        PH_LEN,
        PH_DATA,
        PH_DONE
    } phase_t;

    logic                in_valid_reg;
    tcphp_pkg::in_word_t in_word_reg;
    logic [5:0]          byte_index_reg, byte_index_next;
    logic [5:0]          header_length_reg, header_length_next;
    logic [5:0]          option_left_reg, option_left_next;
    phase_t              phase_reg, phase_next;
    logic [7:0]          fixed_bytes_reg [tcphp_pkg::FIXED_LEN-1];

    logic       advance;
    logic       emit;
    logic       fb_we;
    logic [7:0] b;
    logic       last;
    logic [6:0] nxt;
    logic [6:0] hl;
    logic [3:0] doff;
    logic [5:0] left_dec;
    phase_t     after_opt;

    // The held byte moves on once the result register can take its record.
    assign advance    = in_valid_reg && rec_ready;
    assign byte_stall = in_valid_reg && !rec_ready;
    assign rec_load   = advance && emit;

    assign b         = in_word_reg.header_byte;
    assign last      = in_word_reg.last_byte;
    assign nxt       = {1'b0, byte_index_reg} + 7'd1;
    assign hl        = {1'b0, header_length_reg};
    assign doff      = (fixed_bytes_reg[12][7:4]) & tcphp_pkg::NIBBLE_MASK;
    assign after_opt = (nxt < hl) ? PH_KIND : PH_DONE;
    assign left_dec  = (option_left_reg != 6'd0) ? option_left_reg - 6'd1 : 6'd0;

    always_comb
    begin
        emit               = 1'b0;
        fb_we              = 1'b0;
        rec_word           = '0;
        phase_next         = phase_reg;
        header_length_next = header_length_reg;
        option_left_next   = option_left_reg;

        unique case (phase_reg) inside
            PH_FIXED:
            begin
                if (byte_index_reg < 6'(tcphp_pkg::FIXED_LEN - 1))
                begin
                    fb_we = 1'b1;
                    if (last)
                    begin
                        emit                 = 1'b1;
                        rec_word.record_type = tcphp_pkg::RT_SHORT;
                    end
                end
                else
                begin
                    emit                     = 1'b1;
                    rec_word.record_type     = tcphp_pkg::RT_FIXED;
                    rec_word.src_port        = {fixed_bytes_reg[0], fixed_bytes_reg[1]};
                    rec_word.dst_port        = {fixed_bytes_reg[2], fixed_bytes_reg[3]};
                    rec_word.seq_num         = {fixed_bytes_reg[4], fixed_bytes_reg[5],
                                                fixed_bytes_reg[6], fixed_bytes_reg[7]};
                    rec_word.ack_number      = {fixed_bytes_reg[8], fixed_bytes_reg[9],
                                                fixed_bytes_reg[10], fixed_bytes_reg[11]};
                    rec_word.offset_words    = doff;
                    rec_word.flag_bits       = fixed_bytes_reg[13];
                    rec_word.win_size        = {fixed_bytes_reg[14], fixed_bytes_reg[15]};
                    rec_word.header_checksum = {fixed_bytes_reg[16], fixed_bytes_reg[17]};
                    rec_word.urg_ptr         = {fixed_bytes_reg[18], b};
                    header_length_next       = {doff, 2'b00};
                    phase_next = (doff > 4'(tcphp_pkg::MIN_OFFSET)) ? PH_KIND : PH_DONE;
                end
            end
            PH_KIND, PH_LEN, PH_DATA:
            begin
                if (phase_reg == PH_KIND && b == tcphp_pkg::KIND_EOL)
                begin
                    phase_next = PH_DONE;
                    if (last)
                    begin
                        emit                 = 1'b1;
                        rec_word.record_type = tcphp_pkg::RT_END;
                    end
                end
                else if (last && nxt < hl)
                begin
                    // Header closed before the announced option area was supplied.
                    emit                  = 1'b1;
                    rec_word.record_type  = tcphp_pkg::RT_BAD;
                    rec_word.option_value = b;
                    phase_next            = PH_DONE;
                end
                else if (phase_reg == PH_KIND)
                begin
                    emit                  = 1'b1;
                    rec_word.option_value = b;
                    if (b == tcphp_pkg::KIND_NOP)
                    begin
                        rec_word.record_type = tcphp_pkg::RT_KIND;
                        phase_next           = after_opt;
                    end
                    else if (nxt >= hl)
                    begin
                        rec_word.record_type = tcphp_pkg::RT_BAD;
                        phase_next           = PH_DONE;
                    end
                    else
                    begin
                        rec_word.record_type = tcphp_pkg::RT_KIND;
                        phase_next           = PH_LEN;
                    end
                end
                else if (phase_reg == PH_LEN)
                begin
                    emit                  = 1'b1;
                    rec_word.option_value = b;
                    if (b < 8'd2 || nxt > hl
                        || (b - 8'd2) > {1'b0, hl - nxt})
                    begin
                        rec_word.record_type = tcphp_pkg::RT_BAD;
                        phase_next           = PH_DONE;
                    end
                    else
                    begin
                        rec_word.record_type = tcphp_pkg::RT_LEN;
                        option_left_next     = 6'(b - 8'd2);
                        if (b == 8'd2)
                            phase_next = after_opt;
                        else
                            phase_next = PH_DATA;
                    end
                end
                else
                begin
                    emit                  = 1'b1;
                    rec_word.option_value = b;
                    rec_word.record_type  = tcphp_pkg::RT_DATA;
                    option_left_next      = left_dec;
                    if (left_dec == 6'd0)
                        phase_next = after_opt;
                end
            end
            PH_DONE:
            begin
                if (last)
                begin
                    emit                 = 1'b1;
                    rec_word.record_type = tcphp_pkg::RT_END;
                end
            end
            default:
            begin
                phase_next = PH_FIXED;
            end
        endcase

        rec_word.header_end = last;

        if (last)
        begin
            byte_index_next    = 6'd0;
            header_length_next = 6'd0;
            option_left_next   = 6'd0;
            phase_next         = PH_FIXED;
        end
        else if (byte_index_reg < 6'(tcphp_pkg::IDX_MAX))
        begin
            byte_index_next = nxt[5:0];
        end
        else
        begin
            byte_index_next = 6'(tcphp_pkg::IDX_MAX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg      <= 1'b0;
            byte_index_reg    <= 6'd0;
            header_length_reg <= 6'd0;
            option_left_reg   <= 6'd0;
            phase_reg         <= PH_FIXED;
        end
        else
        begin
            if (!byte_stall)
            begin
                in_valid_reg <= byte_valid;
                if (byte_valid)
                    in_word_reg <= byte_word;
            end
            if (advance)
            begin
                byte_index_reg    <= byte_index_next;
                header_length_reg <= header_length_next;
                option_left_reg   <= option_left_next;
                phase_reg         <= phase_next;
                if (fb_we)
                    fixed_bytes_reg[byte_index_reg[4:0]] <= b;
            end
        end
    end

endmodule

### design/tcphp_out.sv
// ----------------------------------------------------------------------------
// TCP header parser result register
// Holds one record word until the receiver takes it.
// ----------------------------------------------------------------------------
module tcphp_out (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 rec_load,
    input  tcphp_pkg::out_word_t rec_in,
    output logic                 rec_ready,
    output logic                 rec_valid,
    input  logic                 rec_stall,
    output tcphp_pkg::out_word_t rec_word
);

    logic                 valid_reg;
    tcphp_pkg::out_word_t word_reg;

    // The register is free when empty or when its word leaves this cycle.
    assign rec_ready = !valid_reg || !rec_stall;
    assign rec_valid = valid_reg;
    assign rec_word  = word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rec_ready)
        begin
            valid_reg <= rec_load;
            if (rec_load)
                word_reg <= rec_in;
        end
    end

endmodule

### design/tcp_header_option_parser.sv
// ----------------------------------------------------------------------------
// TCP header and option parser
// Turns a byte stream of TCP headers into fixed-header and option records.
// ----------------------------------------------------------------------------
// Usage:
// The byte channel (byte_valid, byte_stall, byte_word) carries one header
// byte per word, with last_byte set on the final byte of each header. The
// record channel (rec_valid, rec_stall, rec_word) returns zero or one record
// word per byte: the fixed-header record on byte 19, then kind, length and
// data records for the options, malformed records for bad or cut-off options,
// and end or short records as the header closes.
// A byte is captured in an input register, decoded by one pass of logic
// and its record is written to the result register once that register is
// free, and the receiver takes it from there. One byte is taken every cycle
// while the record channel keeps up; the input register lets one more byte in
// while a finished record waits to be taken.
// When the receiver stalls, the result register holds its word and the byte
// channel stalls once the input register is also full.
// Reset empties both registers and returns the parser to the start of a
// header; the stored fixed-header bytes are not cleared.
// ----------------------------------------------------------------------------
module tcp_header_option_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_stall,
    input  tcphp_pkg::in_word_t  byte_word,
    output logic                 rec_valid,
    input  logic                 rec_stall,
    output tcphp_pkg::out_word_t rec_word
);

    logic                 rec_ready;
    logic                 rec_load;
    tcphp_pkg::out_word_t rec_next;

    // Byte stage: input register, header state and the decode of one byte.
    tcphp_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_word  (byte_word),
        .rec_ready  (rec_ready),
        .rec_load   (rec_load),
        .rec_word   (rec_next)
    );

    // Result register toward the receiver.
    tcphp_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_load  (rec_load),
        .rec_in    (rec_next),
        .rec_ready (rec_ready),
        .rec_valid (rec_valid),
        .rec_stall (rec_stall),
        .rec_word  (rec_word)
    );

endmodule

### bench/tb_tcp_header_option_parser.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// TCP header and option parser testbench
// Streams TCP headers into the parser one byte per word, predicts each record
// with a behavioral parser of its own or takes it from the directed table,
// and checks each record field by field.
module tb_tcp_header_option_parser;

    // Generous bound on the whole run, in clock cycles.
    localparam int CYCLE_LIMIT  = 200000;
    // Approximate number of random header bytes sent after the directed table.
    localparam int RANDOM_BYTES = 400;
    localparam int NUM_ROWS     = 25;

    // Parse phases of the behavioral parser.
    typedef enum logic [2:0] {
        PH_FIXED,
        PH_KIND,
        PH_LEN,
        PH_DATA,
        PH_DONE
    } parse_phase_t;

    // Kinds of header the random generator builds.
    typedef enum int {
        SHAPE_OPTIONS,
        SHAPE_PLAIN,
        SHAPE_SHORT,
        SHAPE_AT_19,
        SHAPE_BAD_LEN,
        SHAPE_TRUNCATED,
        SHAPE_LONG
    } header_shape_t;

    // One row of the directed table. When typed is set, the record is given
    // here (only short records are typed) instead of by the predictor.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;
        logic [2:0] rtype;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n      = 1'b0;
    logic                 byte_valid = 1'b0;
    logic                 byte_stall;
    tcphp_pkg::in_word_t  byte_word  = '0;
    logic                 rec_valid;
    logic                 rec_stall  = 1'b0;
    tcphp_pkg::out_word_t rec_word;

    // Tag that travels with the byte word being offered.
    logic       row_typed = 1'b0;
    logic [2:0] row_type  = tcphp_pkg::RT_FIXED;

    // Pacing of both channels, in percent of cycles.
    int idle_pct  = 0;
    int stall_pct = 0;

    int bytes_taken    = 0;
    int records_seen   = 0;
    int headers_sent   = 0;
    int fail_count     = 0;
    int cycle_count    = 0;
    int records_by_type [0:7];

    tcphp_pkg::out_word_t pending_records [$];

    // State of the behavioral parser.
    logic [5:0]   hdr_index;
    logic [7:0]   hdr_fixed [0:18];
    logic [5:0]   hdr_length;
    parse_phase_t hdr_phase;
    logic [5:0]   opt_left;

    // Directed table: three short headers of one and three bytes, then a
    // header of all ones, which carries every field at its maximum, a data
    // offset of 15 and ends on byte 19 although it announces options.
    stim_row_t directed_rows [NUM_ROWS] = '{
        '{8'hff, 1'b1, 1'b1, tcphp_pkg::RT_SHORT}, '{8'h00, 1'b1, 1'b1, tcphp_pkg::RT_SHORT},
        '{8'ha5, 1'b0, 1'b0, tcphp_pkg::RT_FIXED}, '{8'h5a, 1'b0, 1'b0, tcphp_pkg::RT_FIXED},
        '{8'hc3, 1'b1, 1'b1, tcphp_pkg::RT_SHORT},
        '{8'hff, 1'b0, 1'b0, tcphp_pkg::RT_FIXED}, '{8'hff, 1'b0, 1'b0, tcphp_pkg::RT_FIXED},
        '{8'hff, 1'b0, 1'b0, tcphp_pkg::RT_FIXED}, '{8'hff, 1'b0, 1'b0, tcphp_pkg::RT_FIXED},
        '{8'hff, 1'b0, 1'b0, tcphp_pkg::RT_FIXED}, '{8'hff, 1'b0, 1'b0, tcphp_pkg::RT_FIXED},
        '{8'hff, 1'b0, 1'b0, tcphp_pkg::RT_FIXED}, '{8'hff, 1'b0, 1'b0, tcphp_pkg::RT_FIXED},
        '{8'hff, 1'b0, 1'b0, tcphp_pkg::RT_FIXED}, '{8'hff, 1'b0, 1'b0, tcphp_pkg::RT_FIXED},
        '{8'hff, 1'b0, 1'b0, tcphp_pkg::RT_FIXED}, '{8'hff, 1'b0, 1'b0, tcphp_pkg::RT_FIXED},
        '{8'hff, 1'b0, 1'b0, tcphp_pkg::RT_FIXED}, '{8'hff, 1'b0, 1'b0, tcphp_pkg::RT_FIXED},
        '{8'hff, 1'b0, 1'b0, tcphp_pkg::RT_FIXED}, '{8'hff, 1'b0, 1'b0, tcphp_pkg::RT_FIXED},
        '{8'hff, 1'b0, 1'b0, tcphp_pkg::RT_FIXED}, '{8'hff, 1'b0, 1'b0, tcphp_pkg::RT_FIXED},
        '{8'hff, 1'b0, 1'b0, tcphp_pkg::RT_FIXED}, '{8'hff, 1'b1, 1'b0, tcphp_pkg::RT_FIXED}
    };

    tcp_header_option_parser DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_word  (byte_word),
        .rec_valid  (rec_valid),
        .rec_stall  (rec_stall),
        .rec_word   (rec_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Behavioral parser
    // ------------------------------------------------------------------------

    // Once an option is complete, the walk goes on with the next kind byte if
    // the option area has room left, otherwise the rest is ignored.
    function automatic parse_phase_t phase_after_option(input int nxt);
        return (nxt < hdr_length) ? PH_KIND : PH_DONE;
    endfunction

    function automatic void reset_parser();
        hdr_index  = '0;
        hdr_length = '0;
        hdr_phase  = PH_FIXED;
        opt_left   = '0;
    endfunction

    // Advances the parser by one byte and returns 1 when the byte yields a
    // record, which is then left in rec.
    function automatic bit predict_record(input tcphp_pkg::in_word_t w,
                                          output tcphp_pkg::out_word_t rec);
        int         idx;
        int         nxt;
        int         hlen;
        int         b;
        logic [3:0] doff;
        bit         emit;
        begin
            idx  = hdr_index;
            nxt  = idx + 1;
            hlen = hdr_length;
            b    = w.header_byte;
            emit = 1'b0;
            rec  = '0;
            case (hdr_phase) inside
                PH_FIXED:
                begin
                    if (idx < tcphp_pkg::FIXED_LEN - 1)
                    begin
                        hdr_fixed[idx] = w.header_byte;
                        if (w.last_byte)
                        begin
                            rec.record_type = tcphp_pkg::RT_SHORT;
                            emit = 1'b1;
                        end
                    end
                    else
                    begin
                        // Byte 19 completes the fixed part of the header.
                        doff = hdr_fixed[12][7:4];
                        rec.src_port        = {hdr_fixed[0], hdr_fixed[1]};
                        rec.dst_port        = {hdr_fixed[2], hdr_fixed[3]};
                        rec.seq_num         = {hdr_fixed[4], hdr_fixed[5],
                                               hdr_fixed[6], hdr_fixed[7]};
                        rec.ack_number      = {hdr_fixed[8], hdr_fixed[9],
                                               hdr_fixed[10], hdr_fixed[11]};
                        rec.offset_words    = doff;
                        rec.flag_bits       = hdr_fixed[13];
                        rec.win_size        = {hdr_fixed[14], hdr_fixed[15]};
                        rec.header_checksum = {hdr_fixed[16], hdr_fixed[17]};
                        rec.urg_ptr         = {hdr_fixed[18], w.header_byte};
                        rec.record_type     = tcphp_pkg::RT_FIXED;
                        emit       = 1'b1;
                        hdr_length = {doff, 2'b00};
                        hdr_phase  = (doff > tcphp_pkg::MIN_OFFSET) ? PH_KIND : PH_DONE;
                    end
                end
                PH_KIND, PH_LEN, PH_DATA:
                begin
                    if (hdr_phase == PH_KIND && w.header_byte == tcphp_pkg::KIND_EOL)
                    begin
                        // End of the option list gives no record of its own unless it closes the header.
                        hdr_phase = PH_DONE;
                        if (w.last_byte)
                        begin
                            rec.record_type = tcphp_pkg::RT_END;
                            emit = 1'b1;
                        end
                    end
                    else if (w.last_byte && nxt < hlen)
                    begin
                        // The header stops before its option area is complete.
                        rec.record_type  = tcphp_pkg::RT_BAD;
                        rec.option_value = w.header_byte;
                        emit      = 1'b1;
                        hdr_phase = PH_DONE;
                    end
                    else if (hdr_phase == PH_KIND)
                    begin
                        emit = 1'b1;
                        rec.option_value = w.header_byte;
                        if (w.header_byte == tcphp_pkg::KIND_NOP)
                        begin
                            rec.record_type = tcphp_pkg::RT_KIND;
                            hdr_phase = phase_after_option(nxt);
                        end
                        else if (nxt >= hlen)
                        begin
                            // No room left for the length byte.
                            rec.record_type = tcphp_pkg::RT_BAD;
                            hdr_phase = PH_DONE;
                        end
                        else
                        begin
                            rec.record_type = tcphp_pkg::RT_KIND;
                            hdr_phase = PH_LEN;
                        end
                    end
                    else if (hdr_phase == PH_LEN)
                    begin
                        emit = 1'b1;
                        rec.option_value = w.header_byte;
                        if (b < 2 || nxt > hlen || (b - 2) > (hlen - nxt))
                        begin
                            rec.record_type = tcphp_pkg::RT_BAD;
                            hdr_phase = PH_DONE;
                        end
                        else
                        begin
                            rec.record_type = tcphp_pkg::RT_LEN;
                            opt_left = 6'(b - 2);
                            if (opt_left == 0)
                                hdr_phase = phase_after_option(nxt);
                            else
                                hdr_phase = PH_DATA;
                        end
                    end
                    else
                    begin
                        emit = 1'b1;
                        rec.option_value = w.header_byte;
                        rec.record_type  = tcphp_pkg::RT_DATA;
                        if (opt_left > 0)
                            opt_left = opt_left - 6'd1;
                        if (opt_left == 0)
                            hdr_phase = phase_after_option(nxt);
                    end
                end
                default:
                begin
                    // Ignored bytes stay silent unless they close the header.
                    if (w.last_byte)
                    begin
                        rec.record_type = tcphp_pkg::RT_END;
                        emit = 1'b1;
                    end
                end
            endcase

            if (w.last_byte)
                reset_parser();
            else
                hdr_index = (idx < tcphp_pkg::IDX_MAX) ? 6'(nxt) : 6'(tcphp_pkg::IDX_MAX);

            rec.header_end = w.last_byte;
            return emit;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Record checking
    // ------------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    function automatic void check_record(input tcphp_pkg::out_word_t got);
        tcphp_pkg::out_word_t want;
        begin
            if (pending_records.size() == 0)
            begin
                $display("%0t: unexpected record, expected none, actual %p", $time, got);
                fail_count++;
            end
            else
            begin
                want = pending_records.pop_front();
                check_field("record_type", want.record_type, got.record_type);
                check_field("header_end", want.header_end, got.header_end);
                check_field("src_port", want.src_port, got.src_port);
                check_field("dst_port", want.dst_port, got.dst_port);
                check_field("seq_num", want.seq_num, got.seq_num);
                check_field("ack_number", want.ack_number, got.ack_number);
                check_field("offset_words", want.offset_words, got.offset_words);
                check_field("flag_bits", want.flag_bits, got.flag_bits);
                check_field("win_size", want.win_size, got.win_size);
                check_field("header_checksum", want.header_checksum, got.header_checksum);
                check_field("urg_ptr", want.urg_ptr, got.urg_ptr);
                check_field("option_value", want.option_value, got.option_value);
            end
        end
    endfunction

    // Both channels are sampled at the rising edge. The record check runs
    // before the new expectation is queued; a record always trails its byte
    // through the input and result registers, so the order cannot hide a real error.
    always @(posedge clk)
    begin : monitor
        tcphp_pkg::out_word_t predicted;
        bit                   has_record;
        if (rst_n)
        begin
            if (rec_valid && !rec_stall)
            begin
                check_record(rec_word);
                records_seen++;
                records_by_type[rec_word.record_type]++;
            end
            if (byte_valid && !byte_stall)
            begin
                has_record = predict_record(byte_word, predicted);
                if (row_typed)
                begin
                    predicted             = '0;
                    predicted.record_type = row_type;
                    predicted.header_end  = byte_word.last_byte;
                    has_record            = 1'b1;
                end
                if (has_record)
                    pending_records = {pending_records, predicted};
                bytes_taken++;
            end
        end
    end

    // The run is bounded; a hung handshake ends here.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d records still expected",
                     $time, cycle_count, pending_records.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver back-pressure, redrawn on every falling edge.
    always @(negedge clk)
    begin
        rec_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    // Offers one byte word at a falling edge and holds it until the monitor
    // has seen it accepted. Valid stays high from one word to the next unless
    // the sender idles in between.
    task automatic send_word(input tcphp_pkg::in_word_t w, input bit typed,
                             input logic [2:0] rtype);
        int seen;
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                byte_valid <= 1'b0;
                @(negedge clk);
            end
            byte_valid <= 1'b1;
            byte_word  <= w;
            row_typed  <= typed;
            row_type   <= rtype;
            seen = bytes_taken;
            do
                @(negedge clk);
            while (bytes_taken == seen);
        end
    endtask

    // Builds one header with random content and sends it. The option area is
    // filled with a mix of end-of-list, NOP and sized options; fault_pct is
    // the chance that a sized option gets a length below 2 or past the area.
    // A nonzero cut ends the header after that many bytes, and extra appends
    // bytes beyond the option area.
    task automatic send_header(input int doff, input int fault_pct, input int cut,
                               input int extra);
        logic [7:0]          hb [$];
        logic [7:0]          kind;
        tcphp_pkg::in_word_t w;
        int                  hlen;
        int                  room;
        int                  len;
        int                  n;
        int                  i;
        begin
            for (i = 0; i < tcphp_pkg::FIXED_LEN; i++)
                hb = {hb, 8'($urandom_range(255))};
            hb[12] = {doff[3:0], hb[12][3:0]};
            hlen = doff * 4;
            while (hb.size() < hlen)
            begin
                room = hlen - hb.size();
                case ($urandom_range(9)) inside
                    0:
                    begin
                        // End of list, then padding that the parser skips.
                        hb = {hb, tcphp_pkg::KIND_EOL};
                        while (hb.size() < hlen)
                            hb = {hb, 8'($urandom_range(255))};
                    end
                    1, 2:
                        hb = {hb, tcphp_pkg::KIND_NOP};
                    default:
                    begin
                        if (room == 1)
                        begin
                            // A kind here is a NOP or a sized kind with no room for its length.
                            hb = {hb, 8'($urandom_range(1, 255))};
                        end
                        else
                        begin
                            kind = 8'($urandom_range(2, 255));
                            hb = {hb, kind};
                            if ($urandom_range(99) < fault_pct)
                                len = $urandom_range(1) ? $urandom_range(0, 1)
                                                        : $urandom_range(room + 1, 255);
                            else
                                len = $urandom_range(2, (room < 12) ? room : 12);
                            hb = {hb, 8'(len)};
                            for (i = 2; i < len && hb.size() < hlen; i++)
                                hb = {hb, 8'($urandom_range(255))};
                        end
                    end
                endcase
            end
            for (i = 0; i < extra; i++)
                hb = {hb, 8'($urandom_range(255))};

            n = (cut > 0 && cut < hb.size()) ? cut : hb.size();
            for (i = 0; i < n; i++)
            begin
                w.header_byte = hb[i];
                w.last_byte   = (i == n - 1);
                send_word(w, 1'b0, tcphp_pkg::RT_FIXED);
            end
            headers_sent++;
        end
    endtask

    initial
    begin : main
        header_shape_t       shape;
        tcphp_pkg::in_word_t w;
        int                  doff;
        int                  sel;
        int                  start_bytes;
        int                  i;

        for (i = 0; i < 8; i++)
            records_by_type[i] = 0;
        reset_parser();

        // Reset is released on a falling edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table, sent back to back.
        for (i = 0; i < NUM_ROWS; i++)
        begin
            w.header_byte = directed_rows[i].data;
            w.last_byte   = directed_rows[i].last;
            send_word(w, directed_rows[i].typed, directed_rows[i].rtype);
        end

        // Random headers. The first few cover every header shape once; after
        // that most headers are well formed with random content. Pacing moves
        // through four phases: none, sender idle, receiver stall, then both.
        start_bytes = bytes_taken;
        i = 0;
        while (bytes_taken - start_bytes < RANDOM_BYTES)
        begin
            case (((bytes_taken - start_bytes) * 4) / RANDOM_BYTES)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 59; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 59; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase

            if (i <= SHAPE_LONG)
                shape = header_shape_t'(i);
            else
            begin
                sel = $urandom_range(99);
                if (sel < 55)      shape = SHAPE_OPTIONS;
                else if (sel < 65) shape = SHAPE_PLAIN;
                else if (sel < 73) shape = SHAPE_SHORT;
                else if (sel < 78) shape = SHAPE_AT_19;
                else if (sel < 86) shape = SHAPE_BAD_LEN;
                else if (sel < 96) shape = SHAPE_TRUNCATED;
                else               shape = SHAPE_LONG;
            end

            doff = $urandom_range(6, 15);
            case (shape)
                SHAPE_OPTIONS:
                    send_header(doff, 0, 0,
                                ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0);
                SHAPE_PLAIN:
                    send_header($urandom_range(0, 5), 0, 0, $urandom_range(0, 4));
                SHAPE_SHORT:
                    send_header($urandom_range(0, 15), 0, $urandom_range(1, 19), 0);
                SHAPE_AT_19:
                    send_header(doff, 0, tcphp_pkg::FIXED_LEN, 0);
                SHAPE_BAD_LEN:
                    send_header(doff, 40, 0, 0);
                SHAPE_TRUNCATED:
                    send_header(doff, 0,
                                $urandom_range(tcphp_pkg::FIXED_LEN + 1, doff * 4 - 1), 0);
                default:
                    // Runs past byte 63 so the byte position saturates.
                    send_header(doff, 0, 0, 70 - doff * 4 + $urandom_range(0, 4));
            endcase
            i++;
        end
        byte_valid <= 1'b0;

        // Drain the records still in flight, then keep watching the record channel
        // for anything that should not be there.
        while (pending_records.size() != 0)
            @(negedge clk);
        stall_pct = 0;
        repeat (10) @(negedge clk);

        $display("Checked %0d records from %0d bytes in %0d headers over four pacing phases.",
                 records_seen, bytes_taken, headers_sent + 4);
        $display("Records by type: fixed %0d, kind %0d, length %0d, data %0d,",
                 records_by_type[tcphp_pkg::RT_FIXED], records_by_type[tcphp_pkg::RT_KIND],
                 records_by_type[tcphp_pkg::RT_LEN], records_by_type[tcphp_pkg::RT_DATA]);
        $display("  end %0d, short %0d, malformed %0d",
                 records_by_type[tcphp_pkg::RT_END], records_by_type[tcphp_pkg::RT_SHORT],
                 records_by_type[tcphp_pkg::RT_BAD]);
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
